FILE: rtl/core/tnmvt_pkg.sv
// tnmvt_pkg: types and constants shared by the top-n max value tracker
// used by the channel interfaces, the cell, the controller, the top level and the checker

package tnmvt_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 32;
   localparam int KEY_W               = 32;
   localparam int VAL_W               = 32;
   localparam int RANK_W              = 5;
   localparam int SIZE_W              = 6;

   localparam logic [SIZE_W-1:0] LIST_SIZE_RESET = SIZE_W'(24);

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_DUMP   = 1'b1
   } req_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } ctrl_state_type;

   // broadcast from controller to every cell
   typedef struct packed {
      logic                    upd;
      logic                    rotate;
      logic                    trim;
      logic                    has_match;
      logic                    room;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
   } cell_ctrl_type;

   // reductions over the row of cells
   typedef struct packed {
      logic match_found;
      logic match_gt;
      logic gt_last;
   } scan_sum_type;

   typedef struct packed {
      logic [RANK_W-1:0]       entry_rank;
      logic [KEY_W-1:0]        entry_key;
      logic signed [VAL_W-1:0] entry_value;
      logic                    entry_valid;
      logic                    last;
   } rsp_word_type;

endpackage

FILE: rtl/core/tnmvt_chan_if.sv
// tnmvt_req_if, tnmvt_rsp_if: valid/ready channels carrying request and result words
// depends on tnmvt_pkg

interface tnmvt_req_if
   import tnmvt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [KEY_W-1:0]        item_key;
   logic signed [VAL_W-1:0] item_value;

   modport source (output valid, output req_type, output item_key, output item_value,
                   input ready);
   modport sink   (input valid, input req_type, input item_key, input item_value,
                   output ready);
endinterface

interface tnmvt_rsp_if
   import tnmvt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [RANK_W-1:0]       entry_rank;
   logic [KEY_W-1:0]        entry_key;
   logic signed [VAL_W-1:0] entry_value;
   logic                    entry_valid;
   logic                    last;

   modport source (output valid, output entry_rank, output entry_key, output entry_value,
                   output entry_valid, output last, input ready);
   modport sink   (input valid, input entry_rank, input entry_key, input entry_value,
                   input entry_valid, input last, output ready);
endinterface

FILE: rtl/core/top_n_max_value_tracker.sv
// top_n_max_value_tracker: ranked list of keys with their largest values, built as a
// row of shifting cells; depends on tnmvt_pkg, tnmvt_chan_if, tnmvt_cell, tnmvt_ctrl
//
// For a sample word every cell compares it against its own entry at once and the row
// shifts by one place on the edge that accepts it, so samples are taken back to back at
// one per cycle while no dump is open. A dump word closes the input until its last result
// is stored; the row rotates one place toward cell 0 per result, and a step waits while
// the result register holds an untaken word (an empty list gives one invalid last word).
// The list size register is to be written only while idle, which the block does not
// enforce. A write drops the lowest ranked entries at once. Reset has no clearing pass.

module top_n_max_value_tracker
   import tnmvt_pkg::*;
#(
   parameter int  MAX_ENTRIES = MAX_ENTRIES_DEFAULT,
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   tnmvt_req_if.sink         req_ch,
   tnmvt_rsp_if.source       rsp_ch,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   logic [KEY_W-1:0]        key_arr   [MAX_ENTRIES];
   logic signed [VAL_W-1:0] value_arr [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]  used_vec;
   logic [MAX_ENTRIES-1:0]  ahead_vec;
   logic [MAX_ENTRIES-1:0]  match_vec;
   logic [MAX_ENTRIES-1:0]  gt_vec;
   logic [MAX_ENTRIES-1:0]  last_vec;
   logic [MAX_ENTRIES-1:0]  tail_vec;

   cell_ctrl_type    cell_ctrl;
   scan_sum_type     sum;
   rsp_word_type     rsp_word;
   logic [CNT_W-1:0] keep_count;

   assign sum.match_found = |match_vec;
   assign sum.match_gt    = |(match_vec & gt_vec);
   assign sum.gt_last     = |(last_vec & gt_vec);

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [KEY_W-1:0]        lk, rk;
      logic signed [VAL_W-1:0] lv, rv;
      logic                    la, lu, ru;

      // matched slot at or beyond this cell
      assign tail_vec[i] = |(match_vec >> i);

      if (i == 0) begin : g_left_end
         assign lk = '0;
         assign lv = '0;
         assign la = 1'b1;
         assign lu = 1'b1;
      end else begin : g_left
         assign lk = key_arr[i-1];
         assign lv = value_arr[i-1];
         assign la = ahead_vec[i-1];
         assign lu = used_vec[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_right_end
         assign rk = '0;
         assign rv = '0;
         assign ru = 1'b0;
      end else begin : g_right
         assign rk = key_arr[i+1];
         assign rv = value_arr[i+1];
         assign ru = used_vec[i+1];
      end

      tnmvt_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .keep_count  (keep_count),
         .match_tail  (tail_vec[i]),
         .left_key    (lk),
         .left_value  (lv),
         .left_ahead  (la),
         .left_used   (lu),
         .right_key   (rk),
         .right_value (rv),
         .right_used  (ru),
         .head_key    (key_arr[0]),
         .head_value  (value_arr[0]),
         .key         (key_arr[i]),
         .value       (value_arr[i]),
         .used        (used_vec[i]),
         .ahead       (ahead_vec[i]),
         .match       (match_vec[i]),
         .gt          (gt_vec[i]),
         .is_last     (last_vec[i])
      );
   end

   tnmvt_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_type    (req_ch.req_type),
      .req_key     (req_ch.item_key),
      .req_value   (req_ch.item_value),
      .req_ready   (req_ch.ready),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .sum         (sum),
      .head_key    (key_arr[0]),
      .head_value  (value_arr[0]),
      .cell_ctrl   (cell_ctrl),
      .keep_count  (keep_count)
   );

   assign rsp_ch.entry_rank  = rsp_word.entry_rank;
   assign rsp_ch.entry_key   = rsp_word.entry_key;
   assign rsp_ch.entry_value = rsp_word.entry_value;
   assign rsp_ch.entry_valid = rsp_word.entry_valid;
   assign rsp_ch.last        = rsp_word.last;

endmodule

FILE: rtl/core/tnmvt_cell.sv
// tnmvt_cell: one rank slot of the sorted list, compares the broadcast sample
// and shifts with its neighbors; depends on tnmvt_pkg

module tnmvt_cell
   import tnmvt_pkg::*;
#(
   parameter int  IDX   = 0,
   parameter int  CNT_W = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctrl_type           ctrl,
   input  logic [CNT_W-1:0]        keep_count,
   input  logic                    match_tail,
   input  logic [KEY_W-1:0]        left_key,
   input  logic signed [VAL_W-1:0] left_value,
   input  logic                    left_ahead,
   input  logic                    left_used,
   input  logic [KEY_W-1:0]        right_key,
   input  logic signed [VAL_W-1:0] right_value,
   input  logic                    right_used,
   input  logic [KEY_W-1:0]        head_key,
   input  logic signed [VAL_W-1:0] head_value,
   output logic [KEY_W-1:0]        key,
   output logic signed [VAL_W-1:0] value,
   output logic                    used,
   output logic                    ahead,
   output logic                    match,
   output logic                    gt,
   output logic                    is_last
);

   logic [KEY_W-1:0]        key_ff, key_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic                    used_ff, used_in;
   logic                    new_first;
   logic                    zone;

   assign key   = key_ff;
   assign value = value_ff;
   assign used  = used_ff;

   assign match     = used_ff & (key_ff == ctrl.key);
   assign gt        = used_ff & (ctrl.value > value_ff);
   assign new_first = (ctrl.value > value_ff) |
                      ((ctrl.value == value_ff) & (ctrl.key < key_ff));
   assign ahead     = used_ff & ~new_first;
   assign is_last   = used_ff & ~right_used;

   // cells that take part in the shift: up to the slot being freed
   assign zone = ctrl.has_match ? match_tail : (ctrl.room ? left_used : used_ff);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.rotate) begin
         key_in   = is_last ? head_key   : right_key;
         value_in = is_last ? head_value : right_value;
      end else if (ctrl.upd && zone && !ahead) begin
         key_in   = left_ahead ? ctrl.key   : left_key;
         value_in = left_ahead ? ctrl.value : left_value;
      end
   end

   always_comb begin
      used_in = used_ff;
      if (ctrl.trim) begin
         used_in = used_ff & (CNT_W'(IDX) < keep_count);
      end else if (ctrl.upd && zone) begin
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

FILE: rtl/core/tnmvt_ctrl.sv
// tnmvt_ctrl: request decode, occupancy, list size register, dump sequencer and
// result register; depends on tnmvt_pkg

module tnmvt_ctrl
   import tnmvt_pkg::*;
#(
   parameter int  MAX_ENTRIES = MAX_ENTRIES_DEFAULT,
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_type,
   input  logic [KEY_W-1:0]        req_key,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output rsp_word_type            rsp_word,
   input  logic                    csr_wr_en,
   input  logic [SIZE_W-1:0]       csr_wr_data,
   input  scan_sum_type            sum,
   input  logic [KEY_W-1:0]        head_key,
   input  logic signed [VAL_W-1:0] head_value,
   output cell_ctrl_type           cell_ctrl,
   output logic [CNT_W-1:0]        keep_count
);

   function automatic logic [CNT_W-1:0] clip_size(input logic [SIZE_W-1:0] sz);
      logic [CNT_W-1:0] res;
      if (sz == '0) begin
         res = CNT_W'(1);
      end else if (int'(sz) > MAX_ENTRIES) begin
         res = CNT_W'(MAX_ENTRIES);
      end else begin
         res = CNT_W'(sz);
      end
      return res;
   endfunction

   ctrl_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0] list_size_ff, list_size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [CNT_W-1:0]  size_cur;
   logic              room;
   logic              req_acc;
   logic              sample_acc;
   logic              dump_acc;
   logic              upd;
   logic              list_empty;
   logic              last_word;
   logic              out_free;
   logic              dump_step;

   assign size_cur   = clip_size(list_size_ff);
   assign keep_count = clip_size(csr_wr_data);
   assign room       = occ_ff < size_cur;
   assign req_acc    = req_valid & req_ready;
   assign sample_acc = req_acc & (req_type == REQ_SAMPLE);
   assign dump_acc   = req_acc & (req_type == REQ_DUMP);
   assign upd        = sample_acc & (sum.match_found ? sum.match_gt : (room | sum.gt_last));
   assign list_empty = (occ_ff == '0);
   assign last_word  = list_empty | ((cnt_ff + CNT_W'(1)) == occ_ff);
   assign out_free   = ~rsp_valid_ff | rsp_ready;

   assign cell_ctrl.upd       = upd;
   assign cell_ctrl.rotate    = dump_step & ~list_empty;
   assign cell_ctrl.trim      = csr_wr_en;
   assign cell_ctrl.has_match = sum.match_found;
   assign cell_ctrl.room      = room;
   assign cell_ctrl.key       = req_key;
   assign cell_ctrl.value     = req_value;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dump_acc) state_in = ST_DUMP;
         end
         ST_DUMP: begin
            if (dump_step && last_word) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dump_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DUMP: dump_step = out_free;
         default: begin
            req_ready = 1'b0;
            dump_step = 1'b0;
         end
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      if (csr_wr_en) begin
         if (occ_ff > keep_count) occ_in = keep_count;
      end else if (upd && !sum.match_found && room) begin
         occ_in = occ_ff + CNT_W'(1);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (dump_acc) begin
         cnt_in = '0;
      end else if (dump_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign list_size_in = csr_wr_en ? csr_wr_data : list_size_ff;
   assign rsp_valid_in = dump_step | (rsp_valid_ff & ~rsp_ready);

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (dump_step) begin
         rsp_word_in.entry_rank  = list_empty ? '0 : RANK_W'(cnt_ff);
         rsp_word_in.entry_key   = list_empty ? '0 : head_key;
         rsp_word_in.entry_value = list_empty ? '0 : head_value;
         rsp_word_in.entry_valid = ~list_empty;
         rsp_word_in.last        = last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         list_size_ff <= LIST_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         list_size_ff <= list_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

FILE: rtl/core/tnmvt_checker.sv
// tnmvt_checker: port level assertions for top_n_max_value_tracker, bound to the top level
// depends on tnmvt_pkg

module tnmvt_checker
   import tnmvt_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_type,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [RANK_W-1:0]       entry_rank,
   input logic [KEY_W-1:0]        entry_key,
   input logic signed [VAL_W-1:0] entry_value,
   input logic                    entry_valid,
   input logic                    last
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_rank) && $stable(entry_key) &&
                                  $stable(entry_value) && $stable(entry_valid) && $stable(last))
      else $error("result word changed while stalled");

   // input closes once a dump word is taken
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_DUMP) |=> !req_ready)
      else $error("input open right after a dump word");

   // empty list word
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !entry_valid |-> last && (entry_rank == '0))
      else $error("invalid result word not a lone last word");

   // ranks of one dump follow without gaps
   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=>
         rsp_valid && (entry_rank == $past(entry_rank) + RANK_W'(1)))
      else $error("dump rank sequence broken");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind top_n_max_value_tracker tnmvt_checker u_tnmvt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_type    (req_ch.req_type),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .entry_rank  (rsp_ch.entry_rank),
   .entry_key   (rsp_ch.entry_key),
   .entry_value (rsp_ch.entry_value),
   .entry_valid (rsp_ch.entry_valid),
   .last        (rsp_ch.last)
);
